/* rtl/ifd_pkg.sv */
package ifd_pkg;

  // Fixed header layout
  localparam int unsigned HeaderBytes = 24;
  localparam int unsigned HdrCountW   = 5;

  // Byte offsets of the header fields
  localparam logic [HdrCountW-1:0] MagicEnd  = 5'd4;
  localparam logic [HdrCountW-1:0] TfrEnd    = 5'd8;
  localparam logic [HdrCountW-1:0] IdentEnd  = 5'd16;
  localparam logic [HdrCountW-1:0] HeaderEnd = 5'(HeaderBytes - 1);

  // Stream characters
  localparam logic [7:0] CharBrace   = 8'h7B;
  localparam logic [7:0] CharNewline = 8'h0A;

  // Configuration register map
  localparam int unsigned PaddrW  = 4;
  localparam logic [1:0] RegFrameMagic  = 2'd0;
  localparam logic [1:0] RegMaxType     = 2'd1;
  localparam logic [1:0] RegMaxPayload  = 2'd2;

  localparam logic [31:0] FrameMagicReset = 32'h5400_0000;
  localparam logic [7:0]  MaxTypeReset    = 8'd8;
  localparam logic [31:0] MaxPayloadReset = 32'd16777216;

  // Parser phases
  localparam logic [1:0] PhIdle    = 2'd0;
  localparam logic [1:0] PhJson    = 2'd1;
  localparam logic [1:0] PhHeader  = 2'd2;
  localparam logic [1:0] PhPayload = 2'd3;

  typedef enum logic [1:0] {
    KindHeader  = 2'd0,
    KindPayload = 2'd1,
    KindJson    = 2'd2,
    KindStatus  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StEof       = 3'd1,
    StTruncated = 3'd2,
    StBadMagic  = 3'd3,
    StBadType   = 3'd4,
    StReserved  = 3'd5,
    StTooBig    = 3'd6,
    StBadFirst  = 3'd7
  } status_e;

  // One result beat
  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [7:0]  out_byte;
    logic [7:0]  frame_kind;
    logic [7:0]  frame_flags;
    logic [63:0] frame_ident;
    logic [31:0] payload_length;
    logic        last;
  } result_t;

endpackage

/* rtl/ipc_frame_deframer_unit.sv */
// Each result beat is registered into the output register, or into the skid register on a stall.
// One input byte per cycle is taken while the skid register is empty; each steps the parser.
// A two-entry output buffer (result register plus skid register) lets input continue for
// one beat while the output side stalls; input stalls only when the skid register is full.
// Reset: rst_ni clears the parser to idle, empties the output buffer and loads the register
// defaults (magic 0x54000000, max type 8, max payload 16777216).
module ipc_frame_deframer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ifd_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,

  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [7:0]                  data_byte_i,

  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic [2:0]                  status_o,
  output logic [7:0]                  out_byte_o,
  output logic [7:0]                  frame_kind_o,
  output logic [7:0]                  frame_flags_o,
  output logic [63:0]                 frame_ident_o,
  output logic [31:0]                 payload_length_o,
  output logic                        last_o
);

  // Configuration registers
  logic [31:0] frame_magic_q;
  logic [7:0]  max_type_q;
  logic [31:0] max_payload_q;

  // Parser state
  logic [1:0]                      phase_q, phase_d;
  logic [ifd_pkg::HdrCountW-1:0]   hdr_count_q, hdr_count_d;
  logic [31:0]                     magic_q, magic_d;
  logic [31:0]                     tfr_q, tfr_d;
  logic [63:0]                     ident_q, ident_d;
  logic [55:0]                     length_q, length_d;
  logic [31:0]                     remaining_q, remaining_d;

  // Output buffer
  logic              out_valid_q, skid_valid_q;
  ifd_pkg::result_t  out_q, skid_q;

  ifd_pkg::result_t              res;
  logic                          res_valid;
  logic                          accept;
  logic                          out_free;
  logic                          cfg_wr;
  logic [1:0]                    cfg_idx;
  logic [ifd_pkg::HdrCountW-1:0] hdr_idx;
  logic                          hdr_byte;
  logic [63:0]                   length_full;
  logic [31:0]                   remaining_dec;
  logic [7:0]                    hdr_type;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ifd_pkg::PaddrW-1:2];
  assign cfg_wr  = psel & penable & pwrite;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_magic_q <= ifd_pkg::FrameMagicReset;
      max_type_q    <= ifd_pkg::MaxTypeReset;
      max_payload_q <= ifd_pkg::MaxPayloadReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ifd_pkg::RegFrameMagic: frame_magic_q <= pwdata;
        ifd_pkg::RegMaxType:    max_type_q    <= pwdata[7:0];
        ifd_pkg::RegMaxPayload: max_payload_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (cfg_idx)
      ifd_pkg::RegFrameMagic: prdata = frame_magic_q;
      ifd_pkg::RegMaxType:    prdata = {24'd0, max_type_q};
      ifd_pkg::RegMaxPayload: prdata = max_payload_q;
      default:                prdata = 32'd0;
    endcase
  end

  // Take a beat unless the skid register is occupied
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i & ~skid_valid_q;

  assign hdr_idx       = (phase_q == ifd_pkg::PhHeader) ? hdr_count_q : '0;
  assign length_full   = {data_byte_i, length_q};
  assign remaining_dec = remaining_q - 32'd1;
  assign hdr_type      = tfr_q[31:24];

  // Parser step: next state and result for the current beat
  always_comb begin
    phase_d     = phase_q;
    hdr_count_d = hdr_count_q;
    magic_d     = magic_q;
    tfr_d       = tfr_q;
    ident_d     = ident_q;
    length_d    = length_q;
    remaining_d = remaining_q;
    res         = '0;
    res_valid   = 1'b0;
    hdr_byte    = 1'b0;

    unique case (phase_q)
      ifd_pkg::PhJson: begin
        res_valid = 1'b1;
        if (cmd_i) begin
          res     = '{kind: ifd_pkg::KindStatus, status: ifd_pkg::StTruncated,
                      last: 1'b1, default: '0};
          phase_d = ifd_pkg::PhIdle;
        end else if (data_byte_i == ifd_pkg::CharNewline) begin
          res     = '{kind: ifd_pkg::KindStatus, status: ifd_pkg::StOk,
                      last: 1'b1, default: '0};
          phase_d = ifd_pkg::PhIdle;
        end else begin
          res.kind     = ifd_pkg::KindJson;
          res.out_byte = data_byte_i;
        end
      end
      ifd_pkg::PhHeader: begin
        if (cmd_i) begin
          res_valid = 1'b1;
          res       = '{kind: ifd_pkg::KindStatus, status: ifd_pkg::StTruncated,
                        last: 1'b1, default: '0};
          phase_d   = ifd_pkg::PhIdle;
        end else begin
          hdr_byte = 1'b1;
        end
      end
      ifd_pkg::PhPayload: begin
        res_valid = 1'b1;
        if (cmd_i) begin
          res     = '{kind: ifd_pkg::KindStatus, status: ifd_pkg::StTruncated,
                      last: 1'b1, default: '0};
          phase_d = ifd_pkg::PhIdle;
        end else begin
          res.kind     = ifd_pkg::KindPayload;
          res.out_byte = data_byte_i;
          remaining_d  = remaining_dec;
          if (remaining_dec == 32'd0) begin
            res.last = 1'b1;
            phase_d  = ifd_pkg::PhIdle;
          end
        end
      end
      default: begin
        if (cmd_i) begin
          res_valid = 1'b1;
          res       = '{kind: ifd_pkg::KindStatus, status: ifd_pkg::StEof,
                        last: 1'b1, default: '0};
        end else if (data_byte_i == ifd_pkg::CharBrace) begin
          res_valid    = 1'b1;
          res.kind     = ifd_pkg::KindJson;
          res.out_byte = data_byte_i;
          phase_d      = ifd_pkg::PhJson;
        end else if (data_byte_i == frame_magic_q[31:24]) begin
          hdr_byte = 1'b1;
          phase_d  = ifd_pkg::PhHeader;
        end else begin
          res_valid = 1'b1;
          res       = '{kind: ifd_pkg::KindStatus, status: ifd_pkg::StBadFirst,
                        last: 1'b1, default: '0};
        end
      end
    endcase

    // Shift a header byte into its field and check the header on its last byte
    if (hdr_byte) begin
      hdr_count_d = hdr_idx + 1'b1;
      if (hdr_idx < ifd_pkg::MagicEnd) begin
        magic_d = {magic_q[23:0], data_byte_i};
      end else if (hdr_idx < ifd_pkg::TfrEnd) begin
        tfr_d = {tfr_q[23:0], data_byte_i};
      end else if (hdr_idx < ifd_pkg::IdentEnd) begin
        ident_d = {data_byte_i, ident_q[63:8]};
      end else begin
        length_d = {data_byte_i, length_q[55:8]};
      end

      if (hdr_idx == ifd_pkg::HeaderEnd) begin
        res_valid = 1'b1;
        phase_d   = ifd_pkg::PhIdle;
        priority if (magic_q != frame_magic_q) begin
          res = '{kind: ifd_pkg::KindStatus, status: ifd_pkg::StBadMagic,
                  last: 1'b1, default: '0};
        end else if (hdr_type == 8'd0 || hdr_type > max_type_q) begin
          res = '{kind: ifd_pkg::KindStatus, status: ifd_pkg::StBadType,
                  last: 1'b1, default: '0};
        end else if (tfr_q[15:0] != 16'd0) begin
          res = '{kind: ifd_pkg::KindStatus, status: ifd_pkg::StReserved,
                  last: 1'b1, default: '0};
        end else if (length_full[63:32] != 32'd0 || length_full[31:0] > max_payload_q) begin
          res = '{kind: ifd_pkg::KindStatus, status: ifd_pkg::StTooBig,
                  last: 1'b1, default: '0};
        end else begin
          res.kind           = ifd_pkg::KindHeader;
          res.frame_kind     = hdr_type;
          res.frame_flags    = tfr_q[23:16];
          res.frame_ident    = ident_q;
          res.payload_length = length_full[31:0];
          res.last           = (length_full[31:0] == 32'd0);
          if (length_full[31:0] != 32'd0) begin
            phase_d     = ifd_pkg::PhPayload;
            remaining_d = length_full[31:0];
          end
        end
      end
    end
  end

  // Advance the parser control state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ifd_pkg::PhIdle;
      hdr_count_q <= '0;
    end else if (accept) begin
      phase_q     <= phase_d;
      hdr_count_q <= hdr_count_d;
    end
  end

  // Hold header fields and payload count; every use follows a full overwrite
  always_ff @(posedge clk_i) begin
    if (accept) begin
      magic_q     <= magic_d;
      tfr_q       <= tfr_d;
      ident_q     <= ident_d;
      length_q    <= length_d;
      remaining_q <= remaining_d;
    end
  end

  assign out_free = ~out_valid_q | ~out_stall_i;

  // Output buffer occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | (accept & res_valid);
      skid_valid_q <= 1'b0;
    end else if (accept & res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output buffer data: skid drains first, so order is kept
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept & res_valid) begin
        out_q <= res;
      end
    end else if (accept & res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign status_o         = out_q.status;
  assign out_byte_o       = out_q.out_byte;
  assign frame_kind_o     = out_q.frame_kind;
  assign frame_flags_o    = out_q.frame_flags;
  assign frame_ident_o    = out_q.frame_ident;
  assign payload_length_o = out_q.payload_length;
  assign last_o           = out_q.last;

endmodule
